>>> rtl/lrukv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache package
// Sizes, types and codes shared by the cache, its register block and its
// request and response interfaces.
// ----------------------------------------------------------------------------
package lrukv_pkg;

	localparam int CAPACITY   = 8;
	localparam int KEY_BITS   = 32;
	localparam int VALUE_BITS = 32;

	localparam int FIELD_BITS = 32;
	localparam int IDX_BITS   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int AGE_BITS   = IDX_BITS;
	localparam int FILL_BITS  = $clog2(CAPACITY + 1);
	localparam int CFG_BITS   = 4;
	localparam int PADDR_BITS = 3;
	localparam int PDATA_BITS = 32;

	typedef logic signed [FIELD_BITS-1:0] field_t;
	typedef logic        [KEY_BITS-1:0]   skey_t;
	typedef logic signed [VALUE_BITS-1:0] svalue_t;
	typedef logic        [IDX_BITS-1:0]   idx_t;
	typedef logic        [AGE_BITS-1:0]   age_t;
	typedef logic        [FILL_BITS-1:0]  fill_t;
	typedef logic        [CFG_BITS-1:0]   cfg_t;
	typedef logic        [PADDR_BITS-1:0] paddr_t;
	typedef logic        [PDATA_BITS-1:0] pdata_t;
	typedef logic        [PADDR_BITS-3:0] reg_idx_t;

	localparam logic     REQ_GET = 1'b0;
	localparam logic     REQ_PUT = 1'b1;

	localparam reg_idx_t REG_CAPACITY   = reg_idx_t'(0);
	localparam cfg_t     CAPACITY_RESET = cfg_t'(8);

	localparam field_t   MISS_VALUE = field_t'(-1);

endpackage

`default_nettype wire

>>> rtl/lrukv_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache channels
// Request and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface lrukv_req_if;
	logic                   valid;
	logic                   ready;
	logic                   req_type;
	lrukv_pkg::field_t      key;
	lrukv_pkg::field_t      put_value;

	modport source (output valid, output req_type, output key, output put_value, input ready);
	modport sink   (input valid, input req_type, input key, input put_value, output ready);
endinterface

interface lrukv_rsp_if;
	logic                   valid;
	logic                   ready;
	logic                   hit;
	lrukv_pkg::field_t      read_value;
	logic                   evicted;

	modport source (output valid, output hit, output read_value, output evicted, input ready);
	modport sink   (input valid, input hit, input read_value, input evicted, output ready);
endinterface

`default_nettype wire

>>> rtl/lrukv_apb_regs.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache register block
// APB-style write and read of the capacity register, and the clamped
// capacity that the store uses.
// ----------------------------------------------------------------------------
module lrukv_apb_regs (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire lrukv_pkg::paddr_t paddr,
	input  wire lrukv_pkg::pdata_t pwdata,
	output lrukv_pkg::pdata_t      prdata,
	output logic                   pready,
	output lrukv_pkg::fill_t       capacity_used
);
	import lrukv_pkg::*;

	cfg_t     capacity_q;
	reg_idx_t reg_idx;
	logic     wr_en;

	assign reg_idx = paddr[PADDR_BITS-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= CAPACITY_RESET;
		end else if (wr_en && (reg_idx == REG_CAPACITY)) begin
			capacity_q <= pwdata[CFG_BITS-1:0];
		end
	end

	always_comb begin
		if (reg_idx == REG_CAPACITY) begin
			prdata = PDATA_BITS'(capacity_q);
		end else begin
			prdata = '0;
		end
	end

	always_comb begin
		if (capacity_q == '0) begin
			capacity_used = fill_t'(1);
		end else if (int'(capacity_q) > CAPACITY) begin
			capacity_used = fill_t'(CAPACITY);
		end else begin
			capacity_used = fill_t'(capacity_q);
		end
	end

endmodule

`default_nettype wire

>>> rtl/lru_key_value_cache.sv
`default_nettype none
// ----------------------------------------------------------------------------
// LRU key/value cache
// Fully associative key/value store with least-recently-used replacement.
// ----------------------------------------------------------------------------
// A request is held in the input register, and its response is registered
// after a single pass of key compare and age update between the input and
// response registers. One request per cycle is taken while the response
// register is empty or being taken; a stalled response holds req.ready low.
// Reset empties the store and sets the capacity register to 8.
// ----------------------------------------------------------------------------
module lru_key_value_cache (
	input  wire logic              clk,
	input  wire logic              arst_n,
	lrukv_req_if.sink              req,
	lrukv_rsp_if.source            rsp,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire lrukv_pkg::paddr_t paddr,
	input  wire lrukv_pkg::pdata_t pwdata,
	output lrukv_pkg::pdata_t      prdata,
	output logic                   pready
);
	import lrukv_pkg::*;

	fill_t   capacity_used;

	logic    valid_s1;
	logic    req_type_s1;
	skey_t   key_s1;
	svalue_t put_value_s1;

	skey_t   keys_q   [CAPACITY];
	svalue_t values_q [CAPACITY];
	logic    [CAPACITY-1:0] entry_valid_q;
	age_t    age_q    [CAPACITY];
	fill_t   fill_q;

	logic    rsp_valid_q;
	logic    hit_q;
	field_t  read_value_q;
	logic    evicted_q;

	logic    advance;

	logic    any_hit;
	idx_t    hit_idx;
	age_t    hit_age;
	logic    lru_found;
	idx_t    lru_idx;
	age_t    lru_age;
	logic    evict_now;
	logic    [CAPACITY-1:0] valid_kept;
	logic    slot_found;
	idx_t    slot_idx;

	logic    [CAPACITY-1:0] entry_valid_d;
	age_t    age_d [CAPACITY];
	fill_t   fill_d;
	logic    wr_key;
	logic    wr_value;
	idx_t    wr_idx;

	lrukv_apb_regs u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.capacity_used (capacity_used)
	);

	assign advance   = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_type_s1  <= req.req_type;
			key_s1       <= KEY_BITS'(req.key);
			put_value_s1 <= VALUE_BITS'(req.put_value);
		end
	end

	always_comb begin
		any_hit = 1'b0;
		hit_idx = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!any_hit && entry_valid_q[i] && (keys_q[i] == key_s1)) begin
				any_hit = 1'b1;
				hit_idx = idx_t'(i);
			end
		end
		hit_age = age_q[hit_idx];
	end

	always_comb begin
		lru_found = 1'b0;
		lru_idx   = '0;
		lru_age   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (entry_valid_q[i] && (!lru_found || (age_q[i] > lru_age))) begin
				lru_found = 1'b1;
				lru_idx   = idx_t'(i);
				lru_age   = age_q[i];
			end
		end
	end

	assign evict_now = (req_type_s1 == REQ_PUT) && !any_hit && (fill_q >= capacity_used)
		&& lru_found;

	always_comb begin
		valid_kept = entry_valid_q;
		if (evict_now) begin
			valid_kept[lru_idx] = 1'b0;
		end
		slot_found = 1'b0;
		slot_idx   = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (!slot_found && !valid_kept[i]) begin
				slot_found = 1'b1;
				slot_idx   = idx_t'(i);
			end
		end
	end

	always_comb begin
		entry_valid_d = entry_valid_q;
		age_d         = age_q;
		fill_d        = fill_q;
		wr_key        = 1'b0;
		wr_value      = 1'b0;
		wr_idx        = hit_idx;
		if (advance) begin
			if (any_hit) begin
				for (int j = 0; j < CAPACITY; j++) begin
					if (entry_valid_q[j] && (age_q[j] < hit_age)) begin
						age_d[j] = age_q[j] + age_t'(1);
					end
				end
				age_d[hit_idx] = '0;
				wr_value       = (req_type_s1 == REQ_PUT);
			end else if (req_type_s1 == REQ_PUT) begin
				entry_valid_d = valid_kept;
				for (int j = 0; j < CAPACITY; j++) begin
					if (valid_kept[j]) begin
						age_d[j] = age_q[j] + age_t'(1);
					end
				end
				if (evict_now && (fill_q != '0)) begin
					fill_d = fill_q - fill_t'(1);
				end
				if (slot_found) begin
					entry_valid_d[slot_idx] = 1'b1;
					age_d[slot_idx]         = '0;
					fill_d                  = fill_d + fill_t'(1);
					wr_key                  = 1'b1;
					wr_value                = 1'b1;
					wr_idx                  = slot_idx;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			fill_q        <= '0;
			for (int i = 0; i < CAPACITY; i++) begin
				age_q[i] <= '0;
			end
		end else begin
			entry_valid_q <= entry_valid_d;
			fill_q        <= fill_d;
			age_q         <= age_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_key) begin
			keys_q[wr_idx] <= key_s1;
		end
		if (wr_value) begin
			values_q[wr_idx] <= put_value_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			hit_q     <= any_hit;
			evicted_q <= evict_now;
			if ((req_type_s1 == REQ_GET) && any_hit) begin
				read_value_q <= FIELD_BITS'(values_q[hit_idx]);
			end else begin
				read_value_q <= MISS_VALUE;
			end
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.hit        = hit_q;
	assign rsp.read_value = read_value_q;
	assign rsp.evicted    = evicted_q;

	// The fill count always matches the number of valid entries.
	a_fill_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(entry_valid_q) == int'(fill_q))
		else $error("fill count differs from the number of valid entries");

	// A request that evicts an entry cannot also have hit.
	a_evict_not_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> !(rsp.hit && rsp.evicted))
		else $error("response shows both hit and eviction");

	// A miss always returns minus one.
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && !rsp.hit) |-> (rsp.read_value == MISS_VALUE))
		else $error("miss response carries a stored value");

	// A put of a new key never leaves the store smaller than it was.
	a_put_keeps_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_type_s1 == REQ_PUT) && !any_hit) |=> (fill_q >= $past(fill_q)))
		else $error("put of a new key reduced the fill count");

	// A get leaves the set of valid entries unchanged.
	a_get_keeps_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (req_type_s1 == REQ_GET)) |=> $stable(entry_valid_q))
		else $error("get request changed the valid entries");

endmodule

`default_nettype wire
